[hdl/eplm_pkg.sv]
// Shared types and constants for the event pair latency monitor.
// No dependencies; imported by every module of the block.
package eplm_pkg;

   // Timestamp and delay width
   localparam int TS_W = 63;

   // Event kinds after classification
   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_TRADE = 2'd1;
   localparam logic [1:0] KIND_QUOTE = 2'd2;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Per-item pair count saturates here
   localparam logic [6:0] PAIR_SAT = 7'd127;

   // Window register reset value
   localparam logic [TS_W-1:0] WINDOW_RESET = 63'd1000000000;

   // One classified item in flight from front to back
   typedef struct packed {
      logic [1:0]      kind;
      logic [TS_W-1:0] ts;
   } item_type;

endpackage

[hdl/event_pair_latency_monitor_top.sv]
// Top level of the event pair latency monitor: window register, front
// queue and back engine, plus assertions. Uses eplm_pkg, eplm_front, eplm_back.
//
// The monitor pairs each trade with the first later quote if that quote
// lies within csr_write_data nanoseconds (the window) and reports, once per
// item, the saturating pair count, saturating delay sum, minimum and
// maximum delay, pairs made by that item and a sticky overflow flag. Items
// enter a two-entry queue, so the port stays open while the engine works
// until the queue is full. The engine handles one item at a time through the
// single read port of the pending-trade ring, one entry a cycle: a trade or
// other item first purges expired entries from the head, a quote sweeps
// every pending entry. No clearing pass is needed after reset. Write the
// window only while the block is idle.
module event_pair_latency_monitor_top
   import eplm_pkg::*;
#(
   parameter int PENDING_DEPTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_en,
   input  logic [TS_W-1:0] csr_write_data,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [1:0]      req_type,
   input  logic [TS_W-1:0] req_timestamp_ns,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [31:0]     rsp_pair_count,
   output logic [TS_W-1:0] rsp_delay_sum_ns,
   output logic [TS_W-1:0] rsp_least_delay_ns,
   output logic [TS_W-1:0] rsp_greatest_delay_ns,
   output logic [6:0]      rsp_pairs_this_item,
   output logic            rsp_overflow_seen
);

   logic [TS_W-1:0] window_ff;
   logic            item_valid;
   item_type        item;
   logic            item_pop;

   // window register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_write_en) begin
         window_ff <= csr_write_data;
      end
   end

   eplm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_timestamp_ns (req_timestamp_ns),
      .item_valid       (item_valid),
      .item             (item),
      .item_pop         (item_pop)
   );

   eplm_back #(
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .window_ns             (window_ff),
      .item_valid            (item_valid),
      .item                  (item),
      .item_pop              (item_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_pair_count        (rsp_pair_count),
      .rsp_delay_sum_ns      (rsp_delay_sum_ns),
      .rsp_least_delay_ns    (rsp_least_delay_ns),
      .rsp_greatest_delay_ns (rsp_greatest_delay_ns),
      .rsp_pairs_this_item   (rsp_pairs_this_item),
      .rsp_overflow_seen     (rsp_overflow_seen)
   );

   // overflow flag never clears once reported
   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_overflow_seen) |=>
         (!rsp_valid || rsp_overflow_seen))
      else $error("overflow flag dropped");

   // with pairs recorded the minimum cannot exceed the maximum
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pair_count != 32'd0) |->
         (rsp_least_delay_ns <= rsp_greatest_delay_ns))
      else $error("min delay above max delay");

   // no pairs yet: extremes still at their reset values
   a_no_pairs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pair_count == 32'd0) |->
         (rsp_least_delay_ns == '1 && rsp_greatest_delay_ns == '0 &&
          rsp_pairs_this_item == 7'd0))
      else $error("statistics set without any pair");

endmodule

[hdl/eplm_front.sv]
// Front end: accepts request items, folds unused kinds into "other" and
// queues them for the back end. Depends on eplm_pkg.
module eplm_front
   import eplm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [1:0]      req_type,
   input  logic [TS_W-1:0] req_timestamp_ns,
   output logic            item_valid,
   output item_type        item,
   input  logic            item_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   item_type         push_item;

   // classify: kind 3 behaves as other
   always_comb begin
      push_item.ts = req_timestamp_ns;
      if (req_type == KIND_TRADE || req_type == KIND_QUOTE) begin
         push_item.kind = req_type;
      end else begin
         push_item.kind = KIND_OTHER;
      end
   end

   assign req_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != '0);
   assign item       = q_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (item_pop && item_valid) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !(item_pop && item_valid)) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && item_pop && item_valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[hdl/eplm_back.sv]
// Back end: ring of pending trade times, head purge, quote sweep with a
// two-stage delay/accumulate pipe, and the result register. Uses eplm_pkg.
module eplm_back
   import eplm_pkg::*;
#(
   parameter int PENDING_DEPTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [TS_W-1:0] window_ns,
   input  logic            item_valid,
   input  item_type        item,
   output logic            item_pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [31:0]     rsp_pair_count,
   output logic [TS_W-1:0] rsp_delay_sum_ns,
   output logic [TS_W-1:0] rsp_least_delay_ns,
   output logic [TS_W-1:0] rsp_greatest_delay_ns,
   output logic [6:0]      rsp_pairs_this_item,
   output logic            rsp_overflow_seen
);

   localparam int IDX_W  = $clog2(PENDING_DEPTH);
   localparam int FILL_W = $clog2(PENDING_DEPTH + 1);
   localparam int SUM_W  = FILL_W + 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PURGE = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [TS_W-1:0]   mem [PENDING_DEPTH];
   logic [TS_W-1:0]   rd_ff;

   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [1:0]        kind_ff, kind_in;
   logic [TS_W-1:0]   now_ff, now_in;
   logic              overflow_ff, overflow_in;
   logic              dv_ff, dv_in;
   logic [TS_W-1:0]   delay_ff;
   logic              ok_ff;
   logic [31:0]       total_pairs_ff, total_pairs_in;
   logic [TS_W-1:0]   total_delay_ff, total_delay_in;
   logic [TS_W-1:0]   least_ff, least_in;
   logic [TS_W-1:0]   greatest_ff, greatest_in;
   logic [6:0]        item_pairs_ff, item_pairs_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              load_rsp;

   logic [TS_W-1:0]   delay_cur;
   logic              over_window;
   logic [IDX_W-1:0]  head_inc;
   logic [SUM_W-1:0]  wr_sum;
   logic [IDX_W-1:0]  wr_addr;
   logic              mem_we;
   logic [TS_W:0]     sum_wide;

   // delay of the entry at the head read port against the current item
   assign delay_cur   = (now_ff >= rd_ff) ? (now_ff - rd_ff) : '0;
   assign over_window = (delay_cur > window_ns);

   assign head_inc = (head_ff == IDX_W'(PENDING_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);

   // tail slot = (head + fill) mod depth
   assign wr_sum  = SUM_W'(head_ff) + SUM_W'(fill_ff);
   assign wr_addr = (wr_sum >= SUM_W'(PENDING_DEPTH)) ?
                    IDX_W'(wr_sum - SUM_W'(PENDING_DEPTH)) : IDX_W'(wr_sum);

   assign sum_wide = {1'b0, total_delay_ff} + {1'b0, delay_ff};

   // sequencer
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      kind_in     = kind_ff;
      now_in      = now_ff;
      overflow_in = overflow_ff;
      dv_in       = 1'b0;
      mem_we      = 1'b0;
      item_pop    = 1'b0;
      load_rsp    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               kind_in  = item.kind;
               now_in   = item.ts;
               state_in = (item.kind == KIND_QUOTE) ? ST_SWEEP : ST_PURGE;
            end
         end
         ST_PURGE: begin
            // drop expired head entries one a cycle, then handle a trade
            if (fill_ff != '0 && over_window) begin
               head_in = head_inc;
               fill_in = fill_ff - FILL_W'(1);
            end else begin
               if (kind_ff == KIND_TRADE) begin
                  if (fill_ff == FILL_W'(PENDING_DEPTH)) begin
                     overflow_in = 1'b1;
                  end else begin
                     mem_we  = 1'b1;
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end
               state_in = ST_DONE;
            end
         end
         ST_SWEEP: begin
            // every pending entry goes through the delay stage, queue empties
            if (fill_ff != '0) begin
               dv_in   = 1'b1;
               head_in = head_inc;
               fill_in = fill_ff - FILL_W'(1);
            end else begin
               head_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // accumulate stage
   always_comb begin
      total_pairs_in = total_pairs_ff;
      total_delay_in = total_delay_ff;
      least_in       = least_ff;
      greatest_in    = greatest_ff;
      item_pairs_in  = item_pairs_ff;
      if (item_pop) begin
         item_pairs_in = '0;
      end
      if (dv_ff && ok_ff) begin
         if (total_pairs_ff != '1) begin
            total_pairs_in = total_pairs_ff + 32'd1;
         end
         total_delay_in = sum_wide[TS_W] ? '1 : sum_wide[TS_W-1:0];
         if (delay_ff < least_ff) begin
            least_in = delay_ff;
         end
         if (delay_ff > greatest_ff) begin
            greatest_in = delay_ff;
         end
         if (item_pairs_ff != PAIR_SAT) begin
            item_pairs_in = item_pairs_ff + 7'd1;
         end
      end
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         fill_ff        <= '0;
         overflow_ff    <= 1'b0;
         dv_ff          <= 1'b0;
         total_pairs_ff <= '0;
         total_delay_ff <= '0;
         least_ff       <= '1;
         greatest_ff    <= '0;
         item_pairs_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         fill_ff        <= fill_in;
         overflow_ff    <= overflow_in;
         dv_ff          <= dv_in;
         total_pairs_ff <= total_pairs_in;
         total_delay_ff <= total_delay_in;
         least_ff       <= least_in;
         greatest_ff    <= greatest_in;
         item_pairs_ff  <= item_pairs_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // item payload and delay stage
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      now_ff   <= now_in;
      delay_ff <= delay_cur;
      ok_ff    <= !over_window;
   end

   // pending ring: read port follows the next head, write bypasses it
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= now_ff;
      end
      if (mem_we && wr_addr == head_in) begin
         rd_ff <= now_ff;
      end else begin
         rd_ff <= mem[head_in];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_pair_count        <= total_pairs_ff;
         rsp_delay_sum_ns      <= total_delay_ff;
         rsp_least_delay_ns    <= least_ff;
         rsp_greatest_delay_ns <= greatest_ff;
         rsp_pairs_this_item   <= item_pairs_ff;
         rsp_overflow_seen     <= overflow_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
